// ===== hdl/ising_metropolis_spin_flip_core_macros.svh =====
// ----------------------------------------------------------------------------
// imsf assertion macros
// shared concurrent assertion forms for the spin flip core checkers
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SPIN_FLIP_CORE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_FLIP_CORE_MACROS_SVH

// same-cycle implication, off while reset is held
`define IMSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imsf check failed");

// next-cycle implication, off while reset is held
`define IMSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imsf check failed");

// next-cycle implication, also checked through reset
`define IMSF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("imsf check failed");

`endif

// ===== hdl/imsf_pkg.sv =====
// ----------------------------------------------------------------------------
// imsf_pkg
// lattice geometry, field widths, threshold bank and queue entry types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imsf_pkg;

  // lattice geometry
  localparam int SIDE    = 64;
  localparam int ROW_AW  = $clog2(SIDE);
  localparam int COORD_W = 6;
  localparam int CMP_W   = (ROW_AW + 1 > COORD_W) ? ROW_AW + 1 : COORD_W;

  // threshold bank
  localparam int THR_W        = 20;
  localparam int DRAW_W       = 20;
  localparam int THR_PER_REG  = 3;
  localparam int NUM_THR_REGS = 6;
  localparam int NUM_THR      = THR_PER_REG * NUM_THR_REGS;
  localparam int THR_IDX_W    = $clog2(NUM_THR);
  localparam int CFG_W        = 60;
  localparam int CFG_IDX_W    = 3;
  localparam logic [CFG_W-1:0] THR_RESET  = 60'd1099512676353000000;
  localparam logic [THR_W-1:0] THR_ALWAYS = 20'd1000000;

  // observables
  localparam int OUT_W  = 14;
  localparam int SUM_W  = 48;
  localparam int MAG_W  = $clog2(SIDE * SIDE) + 2;
  localparam int PAIR_W = $clog2(2 * SIDE * SIDE) + 2;
  localparam int SQ_W   = 2 * MAG_W;
  localparam logic signed [MAG_W-1:0]  MAG_RESET  = MAG_W'(SIDE * SIDE);
  localparam logic signed [PAIR_W-1:0] PAIR_RESET = PAIR_W'(2 * SIDE * (SIDE - 1));

  // front to back queue
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_FLIP  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef logic [NUM_THR_REGS-1:0][CFG_W-1:0] thr_bank_t;

  // classified work item
  typedef struct packed {
    cmd_t              cmd;
    logic              in_range;
    logic [ROW_AW-1:0] row;
    logic [ROW_AW-1:0] col;
    logic              has_up;
    logic              has_dn;
    logic              has_left;
    logic              has_right;
    logic [DRAW_W-1:0] draw;
  } job_t;

endpackage

// ===== hdl/imsf_in_if.sv =====
// ----------------------------------------------------------------------------
// imsf_in_if
// input item channel: flip or clear command with site and random draw
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imsf_in_if import imsf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [DRAW_W-1:0]  random_millionths;

  modport source (output valid, output cmd, output row, output col,
                  output random_millionths, input ready);
  modport sink   (input valid, input cmd, input row, input col,
                  input random_millionths, output ready);
endinterface

// ===== hdl/imsf_out_if.sv =====
// ----------------------------------------------------------------------------
// imsf_out_if
// result channel: accept flag and lattice observables
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imsf_out_if import imsf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic signed [OUT_W-1:0] magnetization;
  logic signed [OUT_W-1:0] pair_sum;
  logic signed [SUM_W-1:0] mag_sum;
  logic [SUM_W-1:0]        mag_sq_sum;

  modport source (output valid, output accepted, output magnetization,
                  output pair_sum, output mag_sum, output mag_sq_sum, input ready);
  modport sink   (input valid, input accepted, input magnetization,
                  input pair_sum, input mag_sum, input mag_sq_sum, output ready);
endinterface

// ===== hdl/imsf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// imsf_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imsf_cfg_if import imsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// ===== hdl/ising_metropolis_spin_flip_core.sv =====
// the back sequencer works on one item at a time: a flip goes through two row-store
//   reads, evaluate/write, square and accumulate, a clear straight to accumulate;
//   accumulate loads the result register once the previous result beat is taken
// a 2-entry queue lets the front take beats while the back works or a result waits
// reset: synchronous, active low; afterwards a clearing pass over all SIDE rows (64)
//   sets every spin up while in_ch.ready stays low; config writes are taken throughout
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip_core
// metropolis spin flip on an open-edge 2d ising lattice with running sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ising_metropolis_spin_flip_core import imsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  imsf_in_if.sink    in_ch,
  imsf_out_if.source out_ch,
  imsf_cfg_if.sink   cfg_ch
);

  thr_bank_t thr_bank;
  logic      init_done;
  logic      q_full;
  logic      q_push;
  job_t      q_job;
  logic      q_valid;
  job_t      q_head;
  logic      q_pop;

  // threshold registers
  imsf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .thr_bank (thr_bank)
  );

  // accept and classify
  imsf_front u_front (
    .in_ch     (in_ch),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // decoupling queue
  imsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (q_head),
    .pop        (q_pop)
  );

  // lattice update and results
  imsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .thr_bank  (thr_bank),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/imsf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// imsf_cfg_regs
// acceptance threshold bank, six packed registers of three entries each
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imsf_cfg_regs import imsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  imsf_cfg_if.sink  cfg_ch,
  output thr_bank_t thr_bank
);

  thr_bank_t thr_bank_r;
  thr_bank_t thr_bank_nxt;
  logic      wr_hit;

  // writes always complete; indexes past the bank are dropped
  assign cfg_ch.ready = 1'b1;
  assign wr_hit = cfg_ch.valid && (cfg_ch.reg_index < CFG_IDX_W'(NUM_THR_REGS));

  always_comb begin
    thr_bank_nxt = thr_bank_r;
    if (wr_hit) begin
      thr_bank_nxt[cfg_ch.reg_index] = cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_THR_REGS; i++) begin
        thr_bank_r[i] <= THR_RESET;
      end
    end else begin
      thr_bank_r <= thr_bank_nxt;
    end
  end

  assign thr_bank = thr_bank_r;

endmodule

// ===== hdl/imsf_front.sv =====
// ----------------------------------------------------------------------------
// imsf_front
// accepts input beats and classifies them: command, range, edge neighbours
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imsf_front import imsf_pkg::*; (
  imsf_in_if.sink in_ch,
  input  logic    init_done,
  input  logic    q_full,
  output logic    q_push,
  output job_t    q_job
);

  logic [CMP_W-1:0] row_w;
  logic [CMP_W-1:0] col_w;

  // take beats once the lattice is cleared and the queue has room
  assign in_ch.ready = init_done && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

  assign row_w = CMP_W'(in_ch.row);
  assign col_w = CMP_W'(in_ch.col);

  // site range and open edge neighbours
  always_comb begin
    q_job.cmd       = cmd_t'(in_ch.cmd);
    q_job.in_range  = (row_w < CMP_W'(SIDE)) && (col_w < CMP_W'(SIDE));
    q_job.row       = ROW_AW'(in_ch.row);
    q_job.col       = ROW_AW'(in_ch.col);
    q_job.has_up    = (row_w != '0);
    q_job.has_dn    = (row_w < CMP_W'(SIDE - 1));
    q_job.has_left  = (col_w != '0);
    q_job.has_right = (col_w < CMP_W'(SIDE - 1));
    q_job.draw      = in_ch.random_millionths;
  end

endmodule

// ===== hdl/imsf_queue.sv =====
// ----------------------------------------------------------------------------
// imsf_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imsf_queue import imsf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  job_t           q_mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QCW-1:0] count_r;
  logic [QCW-1:0] count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    count_nxt = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign full       = (count_r == QCW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = q_mem_r[rd_ptr_r];

endmodule

// ===== hdl/imsf_back.sv =====
// ----------------------------------------------------------------------------
// imsf_back
// lattice row store, metropolis sequencer, observables and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imsf_back import imsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_head,
  output logic       q_pop,
  input  thr_bank_t  thr_bank,
  output logic       init_done,
  imsf_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD1,
    S_EVAL,
    S_SQ,
    S_ACC
  } state_t;

  localparam logic signed [MAG_W-1:0] MAG_STEP = MAG_W'(2);

  // lattice rows, one bit per site, set means spin down
  logic [SIDE-1:0]   spin_mem [SIDE];
  logic [SIDE-1:0]   rd_a_q;
  logic [SIDE-1:0]   rd_b_q;
  logic              mem_rd_en;
  logic [ROW_AW-1:0] rd_a_addr;
  logic [ROW_AW-1:0] rd_b_addr;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_addr;
  logic [SIDE-1:0]   wr_data;

  state_t                   state_r, state_nxt;
  logic [ROW_AW-1:0]        init_cnt_r, init_cnt_nxt;
  job_t                     job_r, job_nxt;
  logic [SIDE-1:0]          cur_row_r, cur_row_nxt;
  logic [SIDE-1:0]          up_row_r, up_row_nxt;
  logic signed [MAG_W-1:0]  mag_r, mag_nxt;
  logic signed [PAIR_W-1:0] pair_r, pair_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic                     acc_r, acc_nxt;
  logic signed [SUM_W-1:0]  mag_sum_r, mag_sum_nxt;
  logic [SUM_W-1:0]         mag_sq_sum_r, mag_sq_sum_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_acc_r, out_acc_nxt;
  logic signed [OUT_W-1:0]  out_mag_r, out_mag_nxt;
  logic signed [OUT_W-1:0]  out_pair_r, out_pair_nxt;

  logic [ROW_AW-1:0]        col_m1;
  logic [ROW_AW-1:0]        col_p1;
  logic                     cur_down;
  logic signed [3:0]        nsum;
  logic [THR_IDX_W-1:0]     thr_idx;
  logic [THR_W-1:0]         thr;
  logic                     accept;
  logic signed [PAIR_W-1:0] pair_step;
  logic [SIDE-1:0]          flip_mask;

  // one neighbour term: +1 up, -1 down, 0 past the edge
  function automatic logic signed [3:0] spin_term(logic valid, logic down);
    logic signed [3:0] t;
    t = 4'sd0;
    if (valid) begin
      t = down ? -4'sd1 : 4'sd1;
    end
    return t;
  endfunction

  // pick one 20-bit threshold out of the packed bank
  function automatic logic [THR_W-1:0] thr_lookup(thr_bank_t bank,
                                                  logic [THR_IDX_W-1:0] e);
    logic [THR_W-1:0] v;
    v = THR_ALWAYS;
    for (int k = 0; k < NUM_THR; k++) begin
      if (e == THR_IDX_W'(k)) begin
        v = bank[k / THR_PER_REG][(k % THR_PER_REG) * THR_W +: THR_W];
      end
    end
    return v;
  endfunction

  // row store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      spin_mem[wr_addr] <= wr_data;
    end
    if (mem_rd_en) begin
      rd_a_q <= spin_mem[rd_a_addr];
      rd_b_q <= spin_mem[rd_b_addr];
    end
  end

  // neighbour sum, threshold and acceptance; row below arrives on port a
  always_comb begin
    col_m1   = job_r.col - ROW_AW'(1);
    col_p1   = job_r.col + ROW_AW'(1);
    cur_down = cur_row_r[job_r.col];
    nsum = spin_term(job_r.has_up,    job_r.has_up    ? up_row_r[job_r.col]  : 1'b0)
         + spin_term(job_r.has_dn,    job_r.has_dn    ? rd_a_q[job_r.col]    : 1'b0)
         + spin_term(job_r.has_left,  job_r.has_left  ? cur_row_r[col_m1]    : 1'b0)
         + spin_term(job_r.has_right, job_r.has_right ? cur_row_r[col_p1]    : 1'b0);
    // new spin is up exactly when the current one is down
    thr_idx   = (cur_down ? THR_IDX_W'(13) : THR_IDX_W'(4)) + THR_IDX_W'(nsum);
    thr       = thr_lookup(thr_bank, thr_idx);
    accept    = job_r.in_range && ((thr >= THR_ALWAYS) || (job_r.draw <= thr));
    pair_step = PAIR_W'(nsum) <<< 1;
    flip_mask = SIDE'(1) << job_r.col;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    job_nxt        = job_r;
    cur_row_nxt    = cur_row_r;
    up_row_nxt     = up_row_r;
    mag_nxt        = mag_r;
    pair_nxt       = pair_r;
    sq_nxt         = sq_r;
    acc_nxt        = acc_r;
    mag_sum_nxt    = mag_sum_r;
    mag_sq_sum_nxt = mag_sq_sum_r;
    out_valid_nxt  = out_valid_r;
    out_acc_nxt    = out_acc_r;
    out_mag_nxt    = out_mag_r;
    out_pair_nxt   = out_pair_r;
    q_pop          = 1'b0;
    mem_rd_en      = 1'b0;
    rd_a_addr      = q_head.row;
    rd_b_addr      = q_head.has_up ? q_head.row - ROW_AW'(1) : q_head.row;
    wr_en          = 1'b0;
    wr_addr        = job_r.row;
    wr_data        = cur_row_r ^ flip_mask;

    // result beat taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        // clearing pass: every row back to all spins up
        wr_en        = 1'b1;
        wr_addr      = init_cnt_r;
        wr_data      = '0;
        init_cnt_nxt = init_cnt_r + ROW_AW'(1);
        if (init_cnt_r == ROW_AW'(SIDE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          job_nxt = q_head;
          acc_nxt = 1'b0;
          if (q_head.cmd == CMD_CLEAR) begin
            state_nxt = S_ACC;
          end else begin
            mem_rd_en = 1'b1;
            state_nxt = S_RD1;
          end
        end
      end
      S_RD1: begin
        // own row and row above land; fetch row below
        cur_row_nxt = rd_a_q;
        up_row_nxt  = rd_b_q;
        mem_rd_en   = 1'b1;
        rd_a_addr   = job_r.has_dn ? job_r.row + ROW_AW'(1) : job_r.row;
        rd_b_addr   = job_r.row;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        acc_nxt = accept;
        if (accept) begin
          wr_en    = 1'b1;
          mag_nxt  = cur_down ? mag_r + MAG_STEP : mag_r - MAG_STEP;
          pair_nxt = cur_down ? pair_r + pair_step : pair_r - pair_step;
        end
        state_nxt = S_SQ;
      end
      S_SQ: begin
        sq_nxt    = SQ_W'(mag_r * mag_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        // running sums and result register, once the last beat is gone
        if (!out_valid_r) begin
          if (job_r.cmd == CMD_CLEAR) begin
            mag_sum_nxt    = '0;
            mag_sq_sum_nxt = '0;
          end else begin
            mag_sum_nxt    = mag_sum_r + SUM_W'(mag_r);
            mag_sq_sum_nxt = mag_sq_sum_r + SUM_W'(sq_r);
          end
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_mag_nxt   = OUT_W'(mag_r);
          out_pair_nxt  = OUT_W'(pair_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    cur_row_r   <= cur_row_nxt;
    up_row_r    <= up_row_nxt;
    sq_r        <= sq_nxt;
    acc_r       <= acc_nxt;
    out_acc_r   <= out_acc_nxt;
    out_mag_r   <= out_mag_nxt;
    out_pair_r  <= out_pair_nxt;
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_cnt_r   <= '0;
      mag_r        <= MAG_RESET;
      pair_r       <= PAIR_RESET;
      mag_sum_r    <= '0;
      mag_sq_sum_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      mag_r        <= mag_nxt;
      pair_r       <= pair_nxt;
      mag_sum_r    <= mag_sum_nxt;
      mag_sq_sum_r <= mag_sq_sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign init_done            = (state_r != S_INIT);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.magnetization = out_mag_r;
  assign out_ch.pair_sum      = out_pair_r;
  assign out_ch.mag_sum       = mag_sum_r;
  assign out_ch.mag_sq_sum    = mag_sq_sum_r;

endmodule

// ===== hdl/imsf_checker.sv =====
// ----------------------------------------------------------------------------
// imsf_checker
// port-level checks on the spin flip core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ising_metropolis_spin_flip_core_macros.svh"

module imsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [13:0] out_magnetization,
  input logic [47:0] out_mag_sum
);

  // clearing pass holds the input closed right after reset
  `IMSF_ASSERT_NEXT_ALWAYS(a_init_closed, clk, !rst_n, !in_ready)

  // a stalled result beat stays up
  `IMSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result beat keeps its accept flag, magnetization and magnetization sum
  `IMSF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                    $stable(out_accepted) && $stable(out_magnetization) && $stable(out_mag_sum))

  // result register only reloads from empty, so a taken beat leaves a gap
  `IMSF_ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && out_ready, !out_valid)

endmodule

bind ising_metropolis_spin_flip_core imsf_checker u_imsf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_accepted      (out_ch.accepted),
  .out_magnetization (out_ch.magnetization),
  .out_mag_sum       (out_ch.mag_sum)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// metropolis spin flip core: directed table then random flips and clears in three
// phases with different source and sink idle rates, each result checked field by
// field against typed table values or a lattice predictor that tracks spins,
// thresholds and running sums
`timescale 1ns / 1ps

module tb;
  import imsf_pkg::*;

  localparam int                 WATCHDOG_LIMIT = 2000;
  localparam int                 DRAIN_CYCLES   = 20;
  localparam int                 PHASE_ITEMS    = 660;
  localparam int                 NUM_PHASES     = 3;
  localparam logic [THR_W-1:0]   THR_EDGE       = 20'd999999;
  localparam logic [DRAW_W-1:0]  DRAW_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_0_2,
    REG_THR_3_5,
    REG_THR_6_8,
    REG_THR_9_11,
    REG_THR_12_14,
    REG_THR_15_17,
    REG_SPARE_6,
    REG_SPARE_7
  } thr_reg_t;

  typedef enum int {
    PROF_KEEP,
    PROF_ZERO,
    PROF_MAX,
    PROF_EDGE,
    PROF_RANDOM
  } thr_profile_t;

  // one result beat as the block shows it
  typedef struct {
    logic                    accepted;
    logic signed [OUT_W-1:0] magnetization;
    logic signed [OUT_W-1:0] pair_sum;
    logic signed [SUM_W-1:0] mag_sum;
    logic [SUM_W-1:0]        mag_sq_sum;
  } obs_t;

  typedef struct {
    thr_profile_t       prof;
    cmd_t               cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DRAW_W-1:0]  draw;
    bit                 typed;
    obs_t               obs;
  } stim_row_t;

  logic clk;
  logic rst_n;

  imsf_in_if  in_bus ();
  imsf_out_if out_bus ();
  imsf_cfg_if cfg_bus ();

  ising_metropolis_spin_flip_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // lattice predictor state
  bit               spin_up [SIDE][SIDE];
  logic [CFG_W-1:0] thr_model [NUM_THR_REGS];
  int               mag_now;
  int               pair_now;
  logic [SUM_W-1:0] mag_acc;
  logic [SUM_W-1:0] sq_acc;

  obs_t      pending_obs [$];
  stim_row_t directed_tbl [$];

  int mismatches;
  int src_idle_pct;
  int snk_idle_pct;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // spin value with open edges
  function automatic int spin_val(int r, int c);
    if (r < 0 || c < 0 || r >= SIDE || c >= SIDE) return 0;
    return spin_up[r][c] ? 1 : -1;
  endfunction

  // one metropolis step on the predictor, returns the expected beat
  function automatic obs_t metropolis_update(cmd_t cmd, int row, int col,
                                             logic [DRAW_W-1:0] draw);
    obs_t             o;
    int               news;
    int               nsum;
    int               idx;
    logic [THR_W-1:0] thr;
    longint           m;
    o.accepted = 1'b0;
    if (cmd == CMD_CLEAR) begin
      mag_acc = '0;
      sq_acc  = '0;
    end else begin
      if (row < SIDE && col < SIDE) begin
        news = -spin_val(row, col);
        nsum = spin_val(row - 1, col) + spin_val(row + 1, col)
             + spin_val(row, col - 1) + spin_val(row, col + 1);
        idx  = (news > 0 ? 9 : 0) + nsum + 4;
        thr  = thr_model[idx / THR_PER_REG][THR_W * (idx % THR_PER_REG) +: THR_W];
        if (thr >= THR_ALWAYS || draw <= thr) begin
          o.accepted        = 1'b1;
          spin_up[row][col] = (news > 0);
          mag_now           = mag_now + 2 * news;
          pair_now          = pair_now + 2 * news * nsum;
        end
      end
      m       = mag_now;
      mag_acc = mag_acc + SUM_W'(m);
      sq_acc  = sq_acc + SUM_W'(m * m);
    end
    o.magnetization = OUT_W'(mag_now);
    o.pair_sum      = OUT_W'(pair_now);
    o.mag_sum       = mag_acc;
    o.mag_sq_sum    = sq_acc;
    return o;
  endfunction

  // mix of always-accept, saturated, tiny and mid-range thresholds
  function automatic logic [THR_W-1:0] random_threshold();
    case ($urandom_range(4))
      0:       return THR_ALWAYS;
      1:       return '1;
      2:       return THR_W'($urandom_range(1000));
      default: return THR_W'($urandom_range(999999));
    endcase
  endfunction

  task automatic add_row(thr_profile_t prof, cmd_t cmd, int row, int col,
                         logic [DRAW_W-1:0] draw, bit typed = 0,
                         logic acc = 0, int mag = 0, int pair = 0,
                         longint msum = 0, longint sqsum = 0);
    stim_row_t s;
    s.prof                = prof;
    s.cmd                 = cmd;
    s.row                 = COORD_W'(row);
    s.col                 = COORD_W'(col);
    s.draw                = draw;
    s.typed               = typed;
    s.obs.accepted        = acc;
    s.obs.magnetization   = OUT_W'(mag);
    s.obs.pair_sum        = OUT_W'(pair);
    s.obs.mag_sum         = SUM_W'(msum);
    s.obs.mag_sq_sum      = SUM_W'(sqsum);
    directed_tbl = {directed_tbl, s};
  endtask

  // present one input beat, hold until taken, then log its expected result
  task automatic drive_site_beat(cmd_t cmd, logic [COORD_W-1:0] row,
                                 logic [COORD_W-1:0] col, logic [DRAW_W-1:0] draw,
                                 bit typed, obs_t typed_obs);
    obs_t pred;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid             = 1'b0;
      in_bus.cmd               = 1'($urandom);
      in_bus.row               = COORD_W'($urandom);
      in_bus.col               = COORD_W'($urandom);
      in_bus.random_millionths = DRAW_W'($urandom);
      @(negedge clk);
    end
    in_bus.valid             = 1'b1;
    in_bus.cmd               = cmd;
    in_bus.row               = row;
    in_bus.col               = col;
    in_bus.random_millionths = draw;
    do @(posedge clk); while (!in_bus.ready);
    pred = metropolis_update(cmd, row, col, draw);
    if (typed) pred = typed_obs;
    pending_obs = {pending_obs, pred};
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_obs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(thr_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid     = 1'b1;
    cfg_bus.reg_index = idx;
    cfg_bus.data      = val;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx < NUM_THR_REGS) thr_model[idx] = val;
  endtask

  // reprogram the whole threshold bank while the core is idle
  task automatic apply_profile(thr_profile_t prof);
    logic [CFG_W-1:0] word;
    wait_drained();
    for (int k = 0; k < NUM_THR_REGS; k++) begin
      case (prof)
        PROF_ZERO: word = '0;
        PROF_MAX:  word = '1;
        PROF_EDGE: word = {THR_PER_REG{THR_EDGE}};
        default:   word = {random_threshold(), random_threshold(), random_threshold()};
      endcase
      write_reg(thr_reg_t'(k), word);
    end
    // unused indexes must leave the bank alone
    if (prof == PROF_RANDOM) begin
      write_reg(REG_SPARE_6, CFG_W'({$urandom, $urandom}));
      write_reg(REG_SPARE_7, CFG_W'({$urandom, $urandom}));
    end
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic check_field(string name, logic signed [63:0] expv,
                             logic signed [63:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  // result beat check
  always @(posedge clk) begin
    obs_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_obs.size() == 0) begin
        $error("result beat with no pending expectation");
        mismatches++;
      end else begin
        want = pending_obs.pop_front();
        check_field("accepted", want.accepted, out_bus.accepted);
        check_field("magnetization", want.magnetization, out_bus.magnetization);
        check_field("pair_sum", want.pair_sum, out_bus.pair_sum);
        check_field("mag_sum", want.mag_sum, out_bus.mag_sum);
        check_field("mag_sq_sum", want.mag_sq_sum, out_bus.mag_sq_sum);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    obs_t               none;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [DRAW_W-1:0]  d;
    cmd_t               cmd;

    // known levels on every input
    rst_n                    = 1'b0;
    in_bus.valid             = 1'b0;
    in_bus.cmd               = 1'b0;
    in_bus.row               = '0;
    in_bus.col               = '0;
    in_bus.random_millionths = '0;
    out_bus.ready            = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.reg_index        = '0;
    cfg_bus.data             = '0;
    mismatches               = 0;
    stall_cycles             = 0;
    src_idle_pct             = 38;
    snk_idle_pct             = 81;
    none                     = '{default: '0};

    // predictor reset state
    foreach (spin_up[i, j]) spin_up[i][j] = 1'b1;
    foreach (thr_model[k]) thr_model[k] = THR_RESET;
    mag_now  = SIDE * SIDE;
    pair_now = 2 * SIDE * (SIDE - 1);
    mag_acc  = '0;
    sq_acc   = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: reset thresholds first, values read straight off the lattice
    add_row(PROF_KEEP, CMD_CLEAR, 63, 63, DRAW_MAX, 1, 0, 4096, 8064, 0, 0);
    add_row(PROF_KEEP, CMD_FLIP, 0, 0, DRAW_MAX, 1, 1, 4094, 8060, 4094, 16760836);
    add_row(PROF_KEEP, CMD_FLIP, 0, 0, 0, 1, 1, 4096, 8064, 8190, 33538052);
    add_row(PROF_KEEP, CMD_FLIP, 63, 63, 500000);
    add_row(PROF_KEEP, CMD_FLIP, 0, 63, 1);
    add_row(PROF_KEEP, CMD_FLIP, 63, 0, 999999);
    add_row(PROF_KEEP, CMD_FLIP, 0, 31, 12345);
    add_row(PROF_KEEP, CMD_FLIP, 31, 0, 0);
    add_row(PROF_KEEP, CMD_FLIP, 63, 31, 777777);
    add_row(PROF_KEEP, CMD_FLIP, 31, 63, 2);
    add_row(PROF_KEEP, CMD_FLIP, 31, 31, DRAW_MAX);
    add_row(PROF_KEEP, CMD_FLIP, 32, 31, 0);
    add_row(PROF_KEEP, CMD_CLEAR, 21, 42, 3);
    // zero thresholds: only a zero draw gets through
    add_row(PROF_ZERO, CMD_FLIP, 10, 10, 0);
    add_row(PROF_KEEP, CMD_FLIP, 10, 11, 1);
    add_row(PROF_KEEP, CMD_FLIP, 10, 11, DRAW_MAX);
    // thresholds one below always-accept: draws around the boundary
    add_row(PROF_EDGE, CMD_FLIP, 20, 20, 999999);
    add_row(PROF_KEEP, CMD_FLIP, 20, 21, 1000000);
    add_row(PROF_KEEP, CMD_FLIP, 20, 21, DRAW_MAX);
    add_row(PROF_KEEP, CMD_FLIP, 20, 21, 999998);
    // saturated thresholds accept everything
    add_row(PROF_MAX, CMD_FLIP, 40, 40, DRAW_MAX);
    add_row(PROF_KEEP, CMD_FLIP, 40, 40, 0);
    add_row(PROF_KEEP, CMD_FLIP, 41, 40, 524288);
    add_row(PROF_KEEP, CMD_CLEAR, 0, 0, 0);

    foreach (directed_tbl[n]) begin
      if (directed_tbl[n].prof != PROF_KEEP) apply_profile(directed_tbl[n].prof);
      drive_site_beat(directed_tbl[n].cmd, directed_tbl[n].row, directed_tbl[n].col,
                      directed_tbl[n].draw, directed_tbl[n].typed, directed_tbl[n].obs);
    end

    // random flips and clears, three phases of source and sink idle rates with a fresh bank each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_profile(PROF_RANDOM);
      src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 81 : 0;
      snk_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 38 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        cmd = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_FLIP;
        r   = COORD_W'($urandom_range(SIDE - 1));
        c   = COORD_W'($urandom_range(SIDE - 1));
        if ($urandom_range(9) == 0) d = DRAW_W'($urandom);
        else d = DRAW_W'($urandom_range(999999));
        drive_site_beat(cmd, r, c, d, 0, none);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
